// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion checked while reset is released.
`define CVP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion checked on every edge, reset included.
`define CVP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cvp_pkg.sv -----
// ----------------------------------------------------------------------------
// cvp_pkg
// Types and constants for the camera vertex projection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cvp_pkg;

    localparam int QBITS    = 18;     // quotient bits before clamping
    localparam int NEAR_Q16 = 6554;   // 0.1 in Q16.16
    localparam int REM_W    = 64;
    localparam int DEN_W    = 46;

    typedef enum logic [2:0] {
        REG_CAM_X    = 3'd0,
        REG_CAM_Y    = 3'd1,
        REG_CAM_Z    = 3'd2,
        REG_COS_YAW  = 3'd3,
        REG_SIN_YAW  = 3'd4,
        REG_COS_TILT = 3'd5,
        REG_SIN_TILT = 3'd6,
        REG_FOCAL    = 3'd7
    } cvp_reg_t;

    typedef struct packed {
        logic               front;
        logic               neg_c;
        logic               neg_r;
        logic               sat_c;
        logic               sat_r;
        logic signed [31:0] depth;
    } cvp_side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem_c;
        logic [REM_W-1:0] rem_r;
        logic [DEN_W-1:0] den;
        logic [QBITS-1:0] q_c;
        logic [QBITS-1:0] q_r;
    } cvp_div_t;

    // divide by 2^14, round half away from zero
    function automatic logic signed [40:0] rnd14(input logic signed [53:0] v);
        logic [53:0] mag;
        logic [53:0] m;
        begin
            mag = v[53] ? 54'(-v) : 54'(v);
            m   = (mag + 54'd8192) >> 14;
            rnd14 = v[53] ? -$signed(41'(m)) : $signed(41'(m));
        end
    endfunction

endpackage

// ----- rtl/cvp_div_stage.sv -----
// ----------------------------------------------------------------------------
// cvp_div_stage
// One restoring-division step for the column and row quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvp_div_stage
    import cvp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  cvp_div_t  in_div,
    input  cvp_side_t in_side,
    output logic      out_valid,
    output cvp_div_t  out_div,
    output cvp_side_t out_side
);

    logic      valid_reg;
    cvp_div_t  div_reg, div_next;
    cvp_side_t side_reg;
    logic [REM_W-1:0] trial;

    always_comb begin
        trial    = REM_W'(in_div.den) << BIT;
        div_next = in_div;
        if (in_div.rem_c >= trial) begin
            div_next.rem_c  = in_div.rem_c - trial;
            div_next.q_c[BIT] = 1'b1;
        end
        if (in_div.rem_r >= trial) begin
            div_next.rem_r  = in_div.rem_r - trial;
            div_next.q_r[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg  <= div_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/camera_vertex_project.sv -----
// ----------------------------------------------------------------------------
// camera_vertex_project
// World vertex to screen projection: camera offset, yaw and tilt rotation,
// perspective divide, rounding and saturation.
// ----------------------------------------------------------------------------
//  channel   ports                              role
//  s_        s_valid/s_ready, s_point_x/y/z     vertex in, Q16.16
//  m_        m_valid/m_ready, m_screen_*, ...   projected vertex out
//  cfg_      cfg_wr_en, cfg_index, cfg_wdata    register writes
//
//  One transaction per cycle while the output is not stalled; the pipeline
//  has 7 arithmetic stages, 18 divider steps and one output stage.
//  Synchronous active-low reset empties the pipeline and loads register
//  defaults. A stalled output holds the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module camera_vertex_project
    import cvp_pkg::*;
#(
    parameter int ROWS = 128,
    parameter int COLS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_screen_row,
    output logic signed [15:0] m_screen_col,
    output logic signed [31:0] m_view_depth,
    output logic               m_in_front
);

    localparam logic signed [19:0] CENTER_R = 20'((ROWS - 1) / 2);
    localparam logic signed [19:0] CENTER_C = 20'((COLS - 1) / 2);

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [15:0] cos_yaw_reg, sin_yaw_reg, cos_tilt_reg, sin_tilt_reg;
    logic        [15:0] focal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg    <= 32'sd0;
            cam_y_reg    <= -32'sd262144;
            cam_z_reg    <= 32'sd98304;
            cos_yaw_reg  <= 16'sd16384;
            sin_yaw_reg  <= 16'sd0;
            cos_tilt_reg <= 16'sd16384;
            sin_tilt_reg <= 16'sd0;
            focal_reg    <= 16'd2040;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CAM_X:    cam_x_reg    <= cfg_wdata;
                REG_CAM_Y:    cam_y_reg    <= cfg_wdata;
                REG_CAM_Z:    cam_z_reg    <= cfg_wdata;
                REG_COS_YAW:  cos_yaw_reg  <= cfg_wdata[15:0];
                REG_SIN_YAW:  sin_yaw_reg  <= cfg_wdata[15:0];
                REG_COS_TILT: cos_tilt_reg <= cfg_wdata[15:0];
                REG_SIN_TILT: sin_tilt_reg <= cfg_wdata[15:0];
                REG_FOCAL:    focal_reg    <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // stage 1: camera offset
    logic signed [32:0] dx1_reg, dy1_reg, dz1_reg;
    // stage 2: yaw products
    logic signed [48:0] xc2_reg, ys2_reg, xs2_reg, yc2_reg;
    logic signed [32:0] dz2_reg;
    // stage 3: yaw sums
    logic signed [36:0] lat3_reg, fwd3_reg;
    logic signed [32:0] dz3_reg;
    // stage 4: tilt products
    logic signed [52:0] fc4_reg, fs4_reg;
    logic signed [48:0] zs4_reg, zc4_reg;
    logic signed [36:0] lat4_reg;
    // stage 5: tilt sums
    logic signed [40:0] depth5_reg, up5_reg;
    logic signed [36:0] lat5_reg;
    // stage 6: focal scaling
    logic [56:0] num_c6_reg, num_r6_reg;
    logic [44:0] d6_reg;
    cvp_side_t   side6_reg;
    // stage 7: rounding bias, saturation check
    cvp_div_t    div7_reg;
    cvp_side_t   side7_reg;

    logic signed [49:0] lat_sum, fwd_sum;
    logic signed [53:0] depth_sum, up_sum;
    logic signed [40:0] lat_full, fwd_full;
    logic [36:0]        lat_mag;
    logic [40:0]        up_mag;
    logic signed [31:0] depth_sat;
    logic               front5;
    logic [58:0]        n_c, n_r;
    logic [REM_W-1:0]   lim;

    always_comb begin
        lat_sum  = 50'(xc2_reg) - 50'(ys2_reg);
        fwd_sum  = 50'(xs2_reg) + 50'(yc2_reg);
        lat_full = rnd14(54'(lat_sum));
        fwd_full = rnd14(54'(fwd_sum));

        depth_sum = 54'(fc4_reg) - 54'(zs4_reg);
        up_sum    = 54'(fs4_reg) + 54'(zc4_reg);

        front5  = depth5_reg >= 41'sd6554;
        lat_mag = lat5_reg[36] ? 37'(-lat5_reg) : 37'(lat5_reg);
        up_mag  = up5_reg[40]  ? 41'(-up5_reg)  : 41'(up5_reg);
        if (depth5_reg > 41'sd2147483647) begin
            depth_sat = 32'sh7fffffff;
        end else if (depth5_reg < -41'sd2147483648) begin
            depth_sat = 32'sh80000000;
        end else begin
            depth_sat = depth5_reg[31:0];
        end

        n_c = {1'b0, num_c6_reg, 1'b0} + 59'(d6_reg);
        n_r = {1'b0, num_r6_reg, 1'b0} + 59'(d6_reg);
        lim = REM_W'({d6_reg, 1'b0}) << QBITS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg <= 33'(s_point_x) - 33'(cam_x_reg);
            dy1_reg <= 33'(s_point_y) - 33'(cam_y_reg);
            dz1_reg <= 33'(s_point_z) - 33'(cam_z_reg);

            xc2_reg <= dx1_reg * cos_yaw_reg;
            ys2_reg <= dy1_reg * sin_yaw_reg;
            xs2_reg <= dx1_reg * sin_yaw_reg;
            yc2_reg <= dy1_reg * cos_yaw_reg;
            dz2_reg <= dz1_reg;

            lat3_reg <= lat_full[36:0];
            fwd3_reg <= fwd_full[36:0];
            dz3_reg  <= dz2_reg;

            fc4_reg  <= fwd3_reg * cos_tilt_reg;
            fs4_reg  <= fwd3_reg * sin_tilt_reg;
            zs4_reg  <= dz3_reg * sin_tilt_reg;
            zc4_reg  <= dz3_reg * cos_tilt_reg;
            lat4_reg <= lat3_reg;

            depth5_reg <= rnd14(depth_sum);
            up5_reg    <= rnd14(up_sum);
            lat5_reg   <= lat4_reg;

            num_c6_reg      <= 57'(lat_mag) * 57'(focal_reg);
            num_r6_reg      <= 57'(up_mag[39:0]) * 57'(focal_reg);
            d6_reg          <= {depth5_reg[40:0], 4'b0};
            side6_reg.front <= front5;
            side6_reg.neg_c <= lat5_reg[36];
            side6_reg.neg_r <= up5_reg[40];
            side6_reg.sat_c <= 1'b0;
            side6_reg.sat_r <= 1'b0;
            side6_reg.depth <= depth_sat;

            div7_reg.rem_c  <= REM_W'(n_c);
            div7_reg.rem_r  <= REM_W'(n_r);
            div7_reg.den    <= {d6_reg, 1'b0};
            div7_reg.q_c    <= '0;
            div7_reg.q_r    <= '0;
            side7_reg       <= {side6_reg.front, side6_reg.neg_c, side6_reg.neg_r,
                                REM_W'(n_c) >= lim, REM_W'(n_r) >= lim,
                                side6_reg.depth};
        end
    end

    // divider steps, most significant quotient bit first
    logic      dv [0:QBITS];
    cvp_div_t  dd [0:QBITS];
    cvp_side_t ds [0:QBITS];

    assign dv[0] = v7_reg;
    assign dd[0] = div7_reg;
    assign ds[0] = side7_reg;

    for (genvar i = 0; i < QBITS; i++) begin : g_div
        cvp_div_stage #(
            .BIT(QBITS - 1 - i)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (dv[i]),
            .in_div   (dd[i]),
            .in_side  (ds[i]),
            .out_valid(dv[i+1]),
            .out_div  (dd[i+1]),
            .out_side (ds[i+1])
        );
    end

    // output stage
    logic [QBITS-1:0]   qc, qr;
    logic signed [19:0] sq_c, sq_r, col_w, row_w;
    logic signed [15:0] row_next, col_next;
    logic signed [15:0] row_reg, col_reg;
    logic signed [31:0] depth_reg;
    logic               front_reg;

    always_comb begin
        qc    = ds[QBITS].sat_c ? {QBITS{1'b1}} : dd[QBITS].q_c;
        qr    = ds[QBITS].sat_r ? {QBITS{1'b1}} : dd[QBITS].q_r;
        sq_c  = ds[QBITS].neg_c ? -$signed(20'(qc)) : $signed(20'(qc));
        sq_r  = ds[QBITS].neg_r ? -$signed(20'(qr)) : $signed(20'(qr));
        col_w = sq_c + CENTER_C;
        row_w = CENTER_R - sq_r;
        if (col_w > 20'sd32767) begin
            col_next = 16'sh7fff;
        end else if (col_w < -20'sd32768) begin
            col_next = 16'sh8000;
        end else begin
            col_next = col_w[15:0];
        end
        if (row_w > 20'sd32767) begin
            row_next = 16'sh7fff;
        end else if (row_w < -20'sd32768) begin
            row_next = 16'sh8000;
        end else begin
            row_next = row_w[15:0];
        end
        if (!ds[QBITS].front) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv[QBITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            depth_reg <= ds[QBITS].depth;
            front_reg <= ds[QBITS].front;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_screen_row = row_reg;
    assign m_screen_col = col_reg;
    assign m_view_depth = depth_reg;
    assign m_in_front   = front_reg;

endmodule

// ----- rtl/cvp_checker.sv -----
// ----------------------------------------------------------------------------
// cvp_checker
// Port-level checks on the projection output, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cvp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_screen_row,
    input logic signed [15:0] m_screen_col,
    input logic signed [31:0] m_view_depth,
    input logic               m_in_front
);

    `CVP_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_view_depth) && $stable(m_screen_row) && $stable(m_screen_col), "stalled transaction changed")
    `CVP_ASSERT(a_behind, aclk, aresetn, m_valid && !m_in_front |-> m_screen_row == 16'sd0 && m_screen_col == 16'sd0, "behind vertex not zeroed")
    `CVP_ASSERT(a_near, aclk, aresetn, m_valid && m_in_front |-> m_view_depth >= 32'sd6554, "front flag with near depth")
    `CVP_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid, "valid out of reset")

endmodule

bind camera_vertex_project cvp_checker u_cvp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_screen_row(m_screen_row),
    .m_screen_col(m_screen_col),
    .m_view_depth(m_view_depth),
    .m_in_front  (m_in_front)
);
